FILE: rtl/wtd_pkg.sv
// ----------------------------------------------------------------------------
// wtd_pkg
// shared types, codes and constants of the waypoint turn-then-drive controller
// ----------------------------------------------------------------------------
`default_nettype none

package wtd_pkg;

  // cordic datapath and angle widths
  localparam int CW = 38;
  localparam int ZW = 18;

  localparam logic signed [CW-1:0] X_UNIT    = 38'sh01_0000_0000;
  localparam logic signed [ZW-1:0] ANG_MAX   = 18'sd32768;
  localparam logic signed [ZW-1:0] ANG_MIN   = -18'sd32768;
  localparam logic signed [ZW-1:0] QUARTER   = 18'sd16384;
  localparam int                   CORDIC_N  = 15;

  // root and divide units
  localparam int SQ_W = 34;
  localparam logic [SQ_W-1:0] SQ_TOP = 34'h1_0000_0000;
  localparam int DV_W = 18;
  localparam int DV_Q = 16;

  // modes
  localparam logic [1:0] MODE_STANDBY = 2'd0;
  localparam logic [1:0] MODE_ROTATE  = 2'd1;
  localparam logic [1:0] MODE_MOVE    = 2'd2;

  // drive directions
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_FWD   = 2'd3;

  // item kinds
  localparam logic KIND_POSE = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // register indexes
  localparam logic [1:0] CFG_WP_COUNT  = 2'd0;
  localparam logic [1:0] CFG_TURN_MAX  = 2'd1;
  localparam logic [1:0] CFG_DRIVE_MAX = 2'd2;

  localparam logic [7:0] TURN_MAX_RST  = 8'd30;
  localparam logic [7:0] DRIVE_MAX_RST = 8'd60;

  // progress and speed constants, q16 progress
  localparam logic [16:0] P_ONE       = 17'd65536;
  localparam logic [16:0] P_ROT_END   = 17'd65471;
  localparam logic [16:0] P_MOVE_END  = 17'd62260;
  localparam logic [16:0] SPEED_FLOOR = 17'd192;
  localparam logic [16:0] HALF_TURN   = 17'd32768;
  localparam logic [16:0] SHORT_DIST  = 17'd50;
  localparam logic [7:0]  SHORT_MAX   = 8'd10;
  localparam logic [4:0]  COEF_LONG   = 5'd20;
  localparam logic [4:0]  COEF_SHORT  = 5'd10;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_BEAR,
    ST_DECIDE,
    ST_PDIV,
    ST_PROG,
    ST_PMUL1,
    ST_PMUL2,
    ST_NUM,
    ST_DEN,
    ST_RDIV,
    ST_SPEED,
    ST_WHEEL,
    ST_OUT
  } state_t;

  function automatic logic signed [ZW-1:0] atan_step(input logic [3:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0:    v = 18'sd8192;
      4'd1:    v = 18'sd4836;
      4'd2:    v = 18'sd2555;
      4'd3:    v = 18'sd1297;
      4'd4:    v = 18'sd651;
      4'd5:    v = 18'sd326;
      4'd6:    v = 18'sd163;
      4'd7:    v = 18'sd81;
      4'd8:    v = 18'sd41;
      4'd9:    v = 18'sd20;
      4'd10:   v = 18'sd10;
      4'd11:   v = 18'sd5;
      4'd12:   v = 18'sd3;
      4'd13:   v = 18'sd1;
      4'd14:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/wtd_ram.sv
// ----------------------------------------------------------------------------
// wtd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module wtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/wtd_cordic.sv
// ----------------------------------------------------------------------------
// wtd_cordic
// iterative vectoring cordic, one rotation per cycle, gives atan2 as binary angle
// ----------------------------------------------------------------------------
`default_nettype none

module wtd_cordic (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [wtd_pkg::CW-1:0]        y_in,
  input  logic signed [wtd_pkg::CW-1:0]        x_in,
  output logic                                 done,
  output logic signed [wtd_pkg::ZW-1:0]        angle
);

  logic signed [wtd_pkg::CW-1:0] x_r, y_r, xs, ys, x_nxt, y_nxt;
  logic signed [wtd_pkg::ZW-1:0] z_r, z_nxt, step, angle_r;
  logic [3:0]                    i_r;
  logic                          busy_r, done_r;

  always_comb begin
    xs   = x_r >>> i_r;
    ys   = y_r >>> i_r;
    step = wtd_pkg::atan_step(i_r);
    if (y_r > 0) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + step;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (x_in == 0 && y_in == 0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && i_r == 4'(wtd_pkg::CORDIC_N - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i_r     <= '0;
      angle_r <= '0;
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r <= y_in;
          y_r <= -x_in;
          z_r <= wtd_pkg::QUARTER;
        end else begin
          x_r <= -y_in;
          y_r <= x_in;
          z_r <= -wtd_pkg::QUARTER;
        end
      end else begin
        x_r <= x_in;
        y_r <= y_in;
        z_r <= '0;
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      i_r <= i_r + 4'd1;
      if (z_nxt > wtd_pkg::ANG_MAX) begin
        angle_r <= wtd_pkg::ANG_MAX;
      end else if (z_nxt < wtd_pkg::ANG_MIN) begin
        angle_r <= wtd_pkg::ANG_MIN;
      end else begin
        angle_r <= z_nxt;
      end
    end
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

`default_nettype wire

FILE: rtl/wtd_sqrt.sv
// ----------------------------------------------------------------------------
// wtd_sqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wtd_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wtd_pkg::SQ_W-1:0]      v_in,
  output logic                          done,
  output logic [16:0]                   root
);

  logic [wtd_pkg::SQ_W-1:0] v_r, r_r, bit_r, v_nxt, r_nxt;
  logic [wtd_pkg::SQ_W:0]   sum;
  logic                     busy_r, done_r;
  logic [16:0]              root_r;

  always_comb begin
    sum = {1'b0, r_r} + {1'b0, bit_r};
    if ({1'b0, v_r} >= sum) begin
      v_nxt = v_r - sum[wtd_pkg::SQ_W-1:0];
      r_nxt = (r_r >> 1) + bit_r;
    end else begin
      v_nxt = v_r;
      r_nxt = r_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == wtd_pkg::SQ_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= v_in;
      r_r   <= '0;
      bit_r <= wtd_pkg::SQ_TOP;
    end else if (busy_r) begin
      v_r    <= v_nxt;
      r_r    <= r_nxt;
      bit_r  <= bit_r >> 2;
      root_r <= r_nxt[16:0];
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

FILE: rtl/wtd_div.sv
// ----------------------------------------------------------------------------
// wtd_div
// restoring divider, gives floor(n * 65536 / d) for n < d, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wtd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wtd_pkg::DV_W-1:0]      n_in,
  input  logic [wtd_pkg::DV_W-1:0]      d_in,
  output logic                          done,
  output logic [wtd_pkg::DV_Q-1:0]      q
);

  logic [wtd_pkg::DV_W-1:0] rem_r, d_r;
  logic [wtd_pkg::DV_W:0]   t;
  logic [wtd_pkg::DV_Q-1:0] q_r;
  logic [3:0]               cnt_r;
  logic                     busy_r, done_r, ge;

  assign t  = {rem_r, 1'b0};
  assign ge = t >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 4'(wtd_pkg::DV_Q - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= n_in;
      d_r   <= d_in;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 4'd1;
      if (ge) begin
        rem_r <= wtd_pkg::DV_W'(t - {1'b0, d_r});
        q_r   <= {q_r[wtd_pkg::DV_Q-2:0], 1'b1};
      end else begin
        rem_r <= t[wtd_pkg::DV_W-1:0];
        q_r   <= {q_r[wtd_pkg::DV_Q-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

`default_nettype wire

FILE: rtl/waypoint_turn_then_drive_controller.sv
// ----------------------------------------------------------------------------
// waypoint_turn_then_drive_controller
// turn-then-drive go-to-goal control of a differential drive over a waypoint route
//
//   channel   dir   handshake            content
//   in_       in    in_tvalid/in_tready  pose tick or waypoint load word
//   out_      out   out_tvalid/out_tready one drive command word per pose tick
//   cfg_      in    cfg_we               route length and peak speeds
//
// a load word is stored without leaving idle; a pose tick's result word comes from
// the serial root, the shared cordic (bearing and two profile angles) and the
// bit-serial divider, run one after the other
// reset clears mode to rotate, route position, captured spans and slot valid bits
// input is held off while a tick is in work; a finished word waits in the output
// register while the next word is taken
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_turn_then_drive_controller #(
  parameter int unsigned ROUTE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // pose_x, pose_y, heading, slot_index, target_x, target_y
  input  logic [0:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // mode, drive_direction, wheels_on, left_speed,
                                  // right_speed, waypoint_number
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int AW = $clog2(ROUTE_DEPTH);

  wtd_pkg::state_t state_r, state_nxt;
  logic entry_r;

  logic [1:0]         mode_r;
  logic [4:0]         pos_r, pos_inc;
  logic signed [17:0] init_turn_r;
  logic [16:0]        init_dist_r;
  logic [4:0]         wp_count_r;
  logic [7:0]         turn_max_r, drive_max_r;
  logic [ROUTE_DEPTH-1:0] slot_valid_r;

  logic signed [15:0] px_r, py_r, hd_r;
  logic signed [16:0] dx_r, dy_r;
  logic [33:0]        acc_r;
  logic [16:0]        dist_r;
  logic signed [17:0] bear_r;
  logic [17:0]        pa_r, pb_r;
  logic [16:0]        p_r;
  logic [1:0]         dir_r;
  logic [4:0]         coef_r;
  logic [7:0]         smax_r;
  logic [34:0]        prof_r;
  logic signed [17:0] num_r, den_r;
  logic [16:0]        ratio_r, s_r;

  logic [1:0]  res_mode_r, res_dir_r;
  logic        res_en_r;
  logic [16:0] res_ls_r, res_rs_r;
  logic [4:0]  res_wp_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;

  // input side
  logic        in_accept, kind, ram_we, slot_ok, pos_ok, out_free;
  logic [31:0] slot_w, pos_w, count_w, eff, pos_inc_w;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] ram_rdata, wp;
  logic        standby_next;

  // arithmetic
  logic [16:0]        abs_dx, abs_dy;
  logic signed [17:0] hd_ext, rel, diff, cur, init_sel;
  logic [17:0]        cur_abs, init_abs;
  logic               prog_special, prog_ge, ratio_special;
  logic signed [16:0] e17;
  logic               e_pos;
  logic [16:0]        factor, speed;
  logic [33:0]        mul_a;
  logic [16:0]        mul_b;
  logic [50:0]        prod;

  // units: shared cordic and divider, and the root unit
  logic                          cordic_start, cordic_done;
  logic signed [wtd_pkg::CW-1:0] cordic_y, cordic_x;
  logic signed [wtd_pkg::ZW-1:0] cordic_angle;
  logic                          sqrt_start, sqrt_done;
  logic [16:0]                   sqrt_root;
  logic                          div_start, div_done;
  logic [wtd_pkg::DV_W-1:0]      div_n, div_d;
  logic [wtd_pkg::DV_Q-1:0]      div_q;

  assign in_tready = (state_r == wtd_pkg::ST_IDLE);
  assign in_accept = in_tvalid & in_tready;
  assign kind      = in_tuser[0];
  assign out_free  = !out_valid_r || out_tready;

  assign slot_w  = {28'd0, in_tdata[51:48]};
  assign slot_ok = slot_w < ROUTE_DEPTH;
  assign waddr   = slot_w[AW-1:0];
  assign ram_we  = in_accept && kind == wtd_pkg::KIND_LOAD && slot_ok;

  assign pos_w  = {27'd0, pos_r};
  assign pos_ok = pos_w < ROUTE_DEPTH;
  assign raddr  = pos_w[AW-1:0];
  assign wp     = (pos_ok && slot_valid_r[raddr]) ? ram_rdata : 32'd0;

  assign count_w      = {27'd0, wp_count_r};
  assign eff          = (count_w < ROUTE_DEPTH) ? count_w : ROUTE_DEPTH;
  assign pos_inc      = pos_r + 5'd1;
  assign pos_inc_w    = {27'd0, pos_inc};
  assign standby_next = pos_inc_w >= eff;

  wtd_ram #(
    .WIDTH (32),
    .DEPTH (ROUTE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_tdata[83:52]),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // distance, bearing and progress terms
  always_comb begin
    abs_dx = dx_r[16] ? 17'(-dx_r) : 17'(dx_r);
    abs_dy = dy_r[16] ? 17'(-dy_r) : 17'(dy_r);
    hd_ext = $signed({{2{hd_r[15]}}, hd_r});
    rel    = bear_r - hd_ext;
    diff   = rel;
    e17    = $signed({diff[15], diff[15:0]});
    e_pos  = $signed(diff[15:0]) > 16'sd0;
    factor = e_pos ? (wtd_pkg::HALF_TURN - 17'(e17)) : (wtd_pkg::HALF_TURN + 17'(e17));
    if (mode_r == wtd_pkg::MODE_ROTATE) begin
      cur      = rel;
      init_sel = (init_turn_r == 18'sd0) ? rel : init_turn_r;
    end else begin
      cur      = $signed({1'b0, dist_r});
      init_sel = (init_dist_r == 17'd0) ? $signed({1'b0, dist_r}) : $signed({1'b0, init_dist_r});
    end
    cur_abs      = cur[17] ? 18'(-cur) : 18'(cur);
    init_abs     = init_sel[17] ? 18'(-init_sel) : 18'(init_sel);
    prog_special = (init_sel == 18'sd0) || (cur == 18'sd0) || (cur[17] != init_sel[17]);
    prog_ge      = cur_abs >= init_abs;
    ratio_special = (cordic_angle <= 18'sd0) || (num_r <= 18'sd0) || (num_r >= cordic_angle);
  end

  assign prod  = mul_a * mul_b;
  assign speed = {1'b0, prod[23:8]} + wtd_pkg::SPEED_FLOOR;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wtd_pkg::ST_IDLE: begin
        if (in_accept && kind == wtd_pkg::KIND_POSE) state_nxt = wtd_pkg::ST_FETCH;
      end
      wtd_pkg::ST_FETCH: state_nxt = wtd_pkg::ST_SQX;
      wtd_pkg::ST_SQX:   state_nxt = wtd_pkg::ST_SQY;
      wtd_pkg::ST_SQY:   state_nxt = wtd_pkg::ST_SQRT;
      wtd_pkg::ST_SQRT: begin
        if (sqrt_done) state_nxt = wtd_pkg::ST_BEAR;
      end
      wtd_pkg::ST_BEAR: begin
        if (cordic_done) state_nxt = wtd_pkg::ST_DECIDE;
      end
      wtd_pkg::ST_DECIDE: begin
        if (mode_r == wtd_pkg::MODE_STANDBY) state_nxt = wtd_pkg::ST_OUT;
        else if (prog_special || prog_ge) state_nxt = wtd_pkg::ST_PROG;
        else state_nxt = wtd_pkg::ST_PDIV;
      end
      wtd_pkg::ST_PDIV: begin
        if (div_done) state_nxt = wtd_pkg::ST_PROG;
      end
      wtd_pkg::ST_PROG: begin
        if (mode_r == wtd_pkg::MODE_ROTATE) begin
          state_nxt = (p_r >= wtd_pkg::P_ROT_END) ? wtd_pkg::ST_OUT : wtd_pkg::ST_PMUL1;
        end else begin
          state_nxt = (p_r >= wtd_pkg::P_MOVE_END) ? wtd_pkg::ST_OUT : wtd_pkg::ST_PMUL1;
        end
      end
      wtd_pkg::ST_PMUL1: state_nxt = wtd_pkg::ST_PMUL2;
      wtd_pkg::ST_PMUL2: state_nxt = wtd_pkg::ST_NUM;
      wtd_pkg::ST_NUM: begin
        if (cordic_done) state_nxt = wtd_pkg::ST_DEN;
      end
      wtd_pkg::ST_DEN: begin
        if (cordic_done) state_nxt = ratio_special ? wtd_pkg::ST_SPEED : wtd_pkg::ST_RDIV;
      end
      wtd_pkg::ST_RDIV: begin
        if (div_done) state_nxt = wtd_pkg::ST_SPEED;
      end
      wtd_pkg::ST_SPEED: begin
        state_nxt = (mode_r == wtd_pkg::MODE_ROTATE) ? wtd_pkg::ST_OUT : wtd_pkg::ST_WHEEL;
      end
      wtd_pkg::ST_WHEEL: state_nxt = wtd_pkg::ST_OUT;
      wtd_pkg::ST_OUT: begin
        if (out_free) state_nxt = wtd_pkg::ST_IDLE;
      end
      default: state_nxt = wtd_pkg::ST_IDLE;
    endcase
  end

  // unit control and multiplier operands
  always_comb begin
    cordic_start = entry_r && (state_r == wtd_pkg::ST_BEAR || state_r == wtd_pkg::ST_NUM ||
                               state_r == wtd_pkg::ST_DEN);
    sqrt_start   = entry_r && state_r == wtd_pkg::ST_SQRT;
    div_start    = entry_r && (state_r == wtd_pkg::ST_PDIV || state_r == wtd_pkg::ST_RDIV);
    cordic_y     = '0;
    cordic_x     = wtd_pkg::X_UNIT;
    div_n        = pa_r;
    div_d        = pb_r;
    mul_a        = '0;
    mul_b        = '0;
    case (state_r)
      wtd_pkg::ST_BEAR: begin
        cordic_y = $signed({{21{dy_r[16]}}, dy_r}) <<< 12;
        cordic_x = $signed({{21{dx_r[16]}}, dx_r}) <<< 12;
      end
      wtd_pkg::ST_NUM: cordic_y = $signed({3'd0, prof_r});
      wtd_pkg::ST_DEN: cordic_y = $signed({3'd0, coef_r, 30'd0});
      wtd_pkg::ST_RDIV: begin
        div_n = num_r;
        div_d = den_r;
      end
      wtd_pkg::ST_SQX: begin
        mul_a = {17'd0, abs_dx};
        mul_b = abs_dx;
      end
      wtd_pkg::ST_SQY: begin
        mul_a = {17'd0, abs_dy};
        mul_b = abs_dy;
      end
      wtd_pkg::ST_PMUL1: begin
        mul_a = {17'd0, p_r};
        mul_b = wtd_pkg::P_ONE - p_r;
      end
      wtd_pkg::ST_PMUL2: begin
        mul_a = acc_r;
        mul_b = {12'd0, coef_r};
      end
      wtd_pkg::ST_SPEED: begin
        mul_a = {26'd0, smax_r};
        mul_b = ratio_r;
      end
      wtd_pkg::ST_WHEEL: begin
        mul_a = {17'd0, s_r};
        mul_b = factor;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wtd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .v_in  (acc_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  wtd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .y_in  (cordic_y),
    .x_in  (cordic_x),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  wtd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n_in  (div_n),
    .d_in  (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wtd_pkg::ST_IDLE;
      entry_r      <= 1'b0;
      mode_r       <= wtd_pkg::MODE_ROTATE;
      pos_r        <= '0;
      init_turn_r  <= '0;
      init_dist_r  <= '0;
      wp_count_r   <= '0;
      turn_max_r   <= wtd_pkg::TURN_MAX_RST;
      drive_max_r  <= wtd_pkg::DRIVE_MAX_RST;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      entry_r <= (state_nxt != state_r);
      if (cfg_we) begin
        case (cfg_index)
          wtd_pkg::CFG_WP_COUNT:  wp_count_r  <= cfg_wdata[4:0];
          wtd_pkg::CFG_TURN_MAX:  turn_max_r  <= cfg_wdata;
          wtd_pkg::CFG_DRIVE_MAX: drive_max_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (ram_we) slot_valid_r[waddr] <= 1'b1;
      if (state_r == wtd_pkg::ST_DECIDE) begin
        if (mode_r == wtd_pkg::MODE_ROTATE) init_turn_r <= init_sel;
        else if (mode_r == wtd_pkg::MODE_MOVE) init_dist_r <= init_sel[16:0];
      end
      if (state_r == wtd_pkg::ST_PROG) begin
        if (mode_r == wtd_pkg::MODE_ROTATE) begin
          if (p_r >= wtd_pkg::P_ROT_END) begin
            mode_r      <= wtd_pkg::MODE_MOVE;
            init_turn_r <= '0;
          end
        end else if (p_r >= wtd_pkg::P_MOVE_END) begin
          init_dist_r <= '0;
          pos_r       <= pos_inc;
          mode_r      <= standby_next ? wtd_pkg::MODE_STANDBY : wtd_pkg::MODE_ROTATE;
        end
      end
      if (state_r == wtd_pkg::ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      wtd_pkg::ST_IDLE: begin
        if (in_accept) begin
          px_r <= $signed(in_tdata[15:0]);
          py_r <= $signed(in_tdata[31:16]);
          hd_r <= $signed(in_tdata[47:32]);
        end
      end
      wtd_pkg::ST_FETCH: begin
        dx_r <= $signed({wp[15], wp[15:0]}) - $signed({px_r[15], px_r});
        dy_r <= $signed({wp[31], wp[31:16]}) - $signed({py_r[15], py_r});
      end
      wtd_pkg::ST_SQX: acc_r <= prod[33:0];
      wtd_pkg::ST_SQY: acc_r <= acc_r + prod[33:0];
      wtd_pkg::ST_SQRT: begin
        if (sqrt_done) dist_r <= sqrt_root;
      end
      wtd_pkg::ST_BEAR: begin
        if (cordic_done) bear_r <= cordic_angle;
      end
      wtd_pkg::ST_DECIDE: begin
        pa_r  <= cur_abs;
        pb_r  <= init_abs;
        p_r   <= prog_special ? wtd_pkg::P_ONE : 17'd0;
        dir_r <= (mode_r == wtd_pkg::MODE_ROTATE) ?
                 ((rel > 18'sd0) ? wtd_pkg::DIR_LEFT : wtd_pkg::DIR_RIGHT) : wtd_pkg::DIR_FWD;
        res_mode_r <= wtd_pkg::MODE_STANDBY;
        res_dir_r  <= wtd_pkg::DIR_NONE;
        res_en_r   <= 1'b0;
        res_ls_r   <= '0;
        res_rs_r   <= '0;
        res_wp_r   <= pos_r;
      end
      wtd_pkg::ST_PDIV: begin
        if (div_done) p_r <= wtd_pkg::P_ONE - {1'b0, div_q};
      end
      wtd_pkg::ST_PROG: begin
        res_dir_r <= dir_r;
        res_en_r  <= 1'b0;
        res_ls_r  <= '0;
        res_rs_r  <= '0;
        if (mode_r == wtd_pkg::MODE_ROTATE) begin
          res_mode_r <= wtd_pkg::MODE_MOVE;
          res_wp_r   <= pos_r;
          coef_r     <= wtd_pkg::COEF_LONG;
          smax_r     <= turn_max_r;
        end else begin
          res_mode_r <= standby_next ? wtd_pkg::MODE_STANDBY : wtd_pkg::MODE_ROTATE;
          res_wp_r   <= pos_inc;
          if (init_dist_r < wtd_pkg::SHORT_DIST) begin
            coef_r <= wtd_pkg::COEF_SHORT;
            smax_r <= wtd_pkg::SHORT_MAX;
          end else begin
            coef_r <= wtd_pkg::COEF_LONG;
            smax_r <= drive_max_r;
          end
        end
      end
      wtd_pkg::ST_PMUL1: acc_r  <= prod[33:0];
      wtd_pkg::ST_PMUL2: prof_r <= prod[34:0];
      wtd_pkg::ST_NUM: begin
        if (cordic_done) num_r <= cordic_angle;
      end
      wtd_pkg::ST_DEN: begin
        if (cordic_done) begin
          den_r   <= cordic_angle;
          ratio_r <= (cordic_angle <= 18'sd0 || num_r <= 18'sd0) ? 17'd0 : wtd_pkg::P_ONE;
        end
      end
      wtd_pkg::ST_RDIV: begin
        if (div_done) ratio_r <= {1'b0, div_q};
      end
      wtd_pkg::ST_SPEED: begin
        s_r        <= speed;
        res_mode_r <= mode_r;
        res_dir_r  <= dir_r;
        res_en_r   <= 1'b1;
        res_ls_r   <= speed;
        res_rs_r   <= speed;
        res_wp_r   <= pos_r;
      end
      wtd_pkg::ST_WHEEL: begin
        if (e_pos) begin
          res_ls_r <= s_r;
          res_rs_r <= prod[31:15];
        end else begin
          res_ls_r <= prod[31:15];
          res_rs_r <= s_r;
        end
      end
      wtd_pkg::ST_OUT: begin
        if (out_free) begin
          out_data_r <= {4'd0, res_wp_r, res_rs_r, res_ls_r, res_en_r, res_dir_r, res_mode_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: dv/tb_waypoint_turn_then_drive_controller.sv
// ----------------------------------------------------------------------------
// tb_waypoint_turn_then_drive_controller
// drives pose ticks and waypoint loads through the controller and checks each
// drive command word against a cycle-free predictor of the turn-then-drive
// control law (cordic bearing, serial root, arctangent speed profile)
// ----------------------------------------------------------------------------
`default_nettype none

module tb_waypoint_turn_then_drive_controller;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0]  wp;
    logic [16:0] rs;
    logic [16:0] ls;
    logic        en;
    logic [1:0]  dir;
    logic [1:0]  mode;
  } drive_cmd_t;

  localparam int SLOTS = 16;
  localparam longint STEP_ANGLE [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41,
                                         20, 10, 5, 3, 1, 1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;   // pose_x, pose_y, heading, slot_index, target_x, target_y
  logic [0:0]  in_tuser = '0;   // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // mode, drive_direction, wheels_on, left_speed,
                                // right_speed, waypoint_number
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;

  waypoint_turn_then_drive_controller dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  longint     route_len, turn_max, drive_max;
  logic [1:0] ctl_mode;
  longint     route_pos, turn_span, dist_span;
  logic [31:0] wp_store [SLOTS];

  drive_cmd_t cmd_q [$];
  int         errors = 0;
  bit         quiet = 0;
  int         stall_left = 0;
  int         gap_left = 0;

  // robot model used to shape the pursuit
  longint rx, ry, rel_now;

  function automatic longint sx16(longint v);
    logic [15:0] w;
    w = v[15:0];
    return longint'($signed(w));
  endfunction

  function automatic longint bam_atan2(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 16384;
      end else begin
        t = x; x = -y; y = t; z = -16384;
      end
    end
    for (int i = 0; i < 15; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += STEP_ANGLE[i];
      end else begin
        x -= ys; y += xs; z -= STEP_ANGLE[i];
      end
    end
    if (z > 32768) z = 32768;
    if (z < -32768) z = -32768;
    return z;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint span_progress(longint cur, longint init);
    longint a, b;
    if (init == 0 || cur == 0) return 65536;
    if ((cur < 0) != (init < 0)) return 65536;
    a = cur < 0 ? -cur : cur;
    b = init < 0 ? -init : init;
    if (a >= b) return 0;
    return 65536 - (a * 65536) / b;
  endfunction

  function automatic longint profile_speed(longint peak, longint p, longint a);
    longint num, den, r;
    num = bam_atan2(a * p * (65536 - p), 64'sd1 << 32);
    den = bam_atan2(a << 30, 64'sd1 << 32);
    r = (den <= 0) ? 0 : (num * 65536) / den;
    if (r < 0) r = 0;
    if (r > 65536) r = 65536;
    return ((peak * r) >> 8) + 192;
  endfunction

  function automatic longint bearing_to(longint px, longint py);
    logic [31:0] w;
    w = (route_pos < SLOTS) ? wp_store[route_pos] : '0;
    return bam_atan2((sx16(w[31:16]) - py) * 4096, (sx16(w[15:0]) - px) * 4096);
  endfunction

  task automatic predict_command(input logic kind, input longint px, py, hd, slot, tx, ty);
    drive_cmd_t c;
    logic [31:0] w;
    longint dx, dy, dist_mm, brg, rel, p, s, e, ls, rs, eff;
    logic [1:0] dir;
    logic en;
    if (kind == wtd_pkg::KIND_LOAD) begin
      if (slot < SLOTS) wp_store[slot] = {ty[15:0], tx[15:0]};
      return;
    end
    w = (route_pos < SLOTS) ? wp_store[route_pos] : '0;
    dx = sx16(w[15:0]) - px;
    dy = sx16(w[31:16]) - py;
    dist_mm = int_sqrt(longint'(dx * dx + dy * dy));
    brg = bam_atan2(dy * 4096, dx * 4096);
    dir = wtd_pkg::DIR_NONE; en = 0; ls = 0; rs = 0;
    if (ctl_mode == wtd_pkg::MODE_ROTATE) begin
      rel = brg - hd;
      if (turn_span == 0) turn_span = rel;
      p = span_progress(rel, turn_span);
      dir = rel > 0 ? wtd_pkg::DIR_LEFT : wtd_pkg::DIR_RIGHT;
      if (p * 1000 > 999 * 65536) begin
        ctl_mode = wtd_pkg::MODE_MOVE;
        turn_span = 0;
      end else begin
        s = profile_speed(turn_max, p, 20);
        ls = s; rs = s; en = 1;
      end
    end else if (ctl_mode == wtd_pkg::MODE_MOVE) begin
      if (dist_span == 0) dist_span = dist_mm;
      p = span_progress(dist_mm, dist_span);
      dir = wtd_pkg::DIR_FWD;
      s = (dist_span < 50) ? profile_speed(10, p, 10) : profile_speed(drive_max, p, 20);
      e = sx16(brg - hd);
      if (p * 100 > 95 * 65536) begin
        dist_span = 0;
        route_pos++;
        eff = route_len < SLOTS ? route_len : SLOTS;
        ctl_mode = route_pos >= eff ? wtd_pkg::MODE_STANDBY : wtd_pkg::MODE_ROTATE;
      end else begin
        if (e > 0) begin
          ls = s; rs = (s * (32768 - e)) >> 15;
        end else begin
          ls = (s * (32768 + e)) >> 15; rs = s;
        end
        en = 1;
      end
    end
    c.mode = ctl_mode;
    c.dir = dir;
    c.en = en;
    c.ls = ls[16:0];
    c.rs = rs[16:0];
    c.wp = route_pos[4:0];
    cmd_q.push_back(c);
  endtask

  task automatic send_word(input logic kind, input longint px, py, hd, slot, tx, ty);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {4'b0, ty[15:0], tx[15:0], slot[3:0], hd[15:0], py[15:0], px[15:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_command(kind, px, py, hd, slot, tx, ty);
  endtask

  task automatic pose_tick(input longint px, py, hd);
    send_word(wtd_pkg::KIND_POSE, px, py, hd, longint'($urandom_range(0, 15)),
              sx16(longint'($urandom)), sx16(longint'($urandom)));
  endtask

  task automatic load_slot(input longint slot, tx, ty);
    send_word(wtd_pkg::KIND_LOAD, sx16(longint'($urandom)), sx16(longint'($urandom)),
              sx16(longint'($urandom)), slot, tx, ty);
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      wtd_pkg::CFG_WP_COUNT:  route_len = longint'(val[4:0]);
      wtd_pkg::CFG_TURN_MAX:  turn_max = longint'(val);
      wtd_pkg::CFG_DRIVE_MAX: drive_max = longint'(val);
      default: ;
    endcase
  endtask

  // loads at the field extremes and into both end slots
  task automatic test_loads;
    load_slot(0, 1000, 0);
    load_slot(15, 32767, -32768);
    load_slot(3, -32768, 32767);
    load_slot(1, 0, 0);
    load_slot(2, 30, -20);
  endtask

  // empty route: first turn toward slot 0 still runs; zero turn span ends it at once
  task automatic test_empty_route_turn;
    pose_tick(0, 0, 0);
    pose_tick(0, 0, -32768);
    pose_tick(0, 0, 32767);
    pose_tick(-32768, 32767, 12000);
    pose_tick(500, 0, -5);
  endtask

  // move reaches the waypoint, then a zero distance span on slot 1
  task automatic test_route_steps;
    pose_tick(1000, 0, 0);
    pose_tick(1000, 0, -32768);
    pose_tick(1000, 0, 32767);
    pose_tick(1000, 0, 0);
    pose_tick(0, 0, 100);
    pose_tick(32767, -32768, 0);
  endtask

  // pursuit: turn converges, then the robot closes in on the waypoint, with random loads and poses mixed in
  task automatic test_pursuit(input int n);
    logic [31:0] w;
    longint tx, ty, b, hd;
    for (int k = 0; k < n; k++) begin
      w = (route_pos < SLOTS) ? wp_store[route_pos] : '0;
      tx = sx16(w[15:0]);
      ty = sx16(w[31:16]);
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1)) begin
          load_slot(longint'($urandom_range(0, 15)), sx16(longint'($urandom)),
                    sx16(longint'($urandom)));
        end else begin
          pose_tick(sx16(longint'($urandom)), sx16(longint'($urandom)),
                    sx16(longint'($urandom)));
        end
        rel_now = 0;
      end else if (ctl_mode == wtd_pkg::MODE_ROTATE) begin
        if (turn_span == 0 || rel_now == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            rx = sx16(tx + longint'($urandom_range(0, 80)) - 40);
            ry = sx16(ty + longint'($urandom_range(0, 80)) - 40);
          end else begin
            rx = sx16(longint'($urandom));
            ry = sx16(longint'($urandom));
          end
          hd = sx16(longint'($urandom));
        end else begin
          rel_now = rel_now * longint'($urandom_range(13, 16)) / 16;
          if ($urandom_range(0, 31) == 0) rel_now = 0;
          hd = sx16(bearing_to(rx, ry) - rel_now);
        end
        b = bearing_to(rx, ry);
        rel_now = b - hd;
        pose_tick(rx, ry, hd);
      end else if (ctl_mode == wtd_pkg::MODE_MOVE) begin
        if (dist_span != 0) begin
          if ($urandom_range(0, 19) == 0) begin
            rx = tx; ry = ty;
          end else begin
            rx = sx16(tx + (rx - tx) * longint'($urandom_range(10, 15)) / 16);
            ry = sx16(ty + (ry - ty) * longint'($urandom_range(10, 15)) / 16);
          end
        end
        hd = sx16(bearing_to(rx, ry) + longint'($urandom_range(0, 4000)) - 2000);
        pose_tick(rx, ry, hd);
        rel_now = 0;
      end else begin
        pose_tick(sx16(longint'($urandom)), sx16(longint'($urandom)),
                  sx16(longint'($urandom)));
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!quiet && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 15);
    out_tready = (stall_left == 0);
  end

  always @(posedge clk) begin
    drive_cmd_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[43:0];
      if (cmd_q.size() == 0) begin
        errors++;
        $display("%0t unexpected word: actual %h", $time, got);
      end else begin
        want = cmd_q.pop_front();
        if (got.mode !== want.mode || got.dir !== want.dir || got.en !== want.en ||
            got.ls !== want.ls || got.rs !== want.rs || got.wp !== want.wp) begin
          errors++;
          $display("%0t mismatch: expected mode %0d dir %0d en %0d l %0d r %0d wp %0d",
                   $time, want.mode, want.dir, want.en, want.ls, want.rs, want.wp);
          $display("%0t           actual mode %0d dir %0d en %0d l %0d r %0d wp %0d",
                   $time, got.mode, got.dir, got.en, got.ls, got.rs, got.wp);
        end
      end
    end
  end

  initial begin
    route_len = 0;
    turn_max = longint'(wtd_pkg::TURN_MAX_RST);
    drive_max = longint'(wtd_pkg::DRIVE_MAX_RST);
    ctl_mode = wtd_pkg::MODE_ROTATE; route_pos = 0; turn_span = 0; dist_span = 0;
    rx = 0; ry = 0; rel_now = 0;
    for (int i = 0; i < SLOTS; i++) wp_store[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_loads();
    test_empty_route_turn();
    write_reg(wtd_pkg::CFG_WP_COUNT, 8'd16);
    test_route_steps();
    write_reg(wtd_pkg::CFG_TURN_MAX, 8'd255);
    write_reg(wtd_pkg::CFG_DRIVE_MAX, 8'd0);
    test_pursuit(300);
    write_reg(wtd_pkg::CFG_TURN_MAX, 8'd0);
    write_reg(wtd_pkg::CFG_DRIVE_MAX, 8'd255);
    test_pursuit(300);
    drain();
    test_pursuit(300);
    write_reg(wtd_pkg::CFG_TURN_MAX, 8'($urandom_range(1, 254)));
    write_reg(wtd_pkg::CFG_DRIVE_MAX, 8'($urandom_range(1, 254)));
    test_pursuit(400);
    write_reg(wtd_pkg::CFG_TURN_MAX, 8'd30);
    write_reg(wtd_pkg::CFG_DRIVE_MAX, 8'd60);
    write_reg(wtd_pkg::CFG_WP_COUNT, 8'($urandom_range(32'(route_pos + 1), 16)));
    test_pursuit(400);
    write_reg(wtd_pkg::CFG_WP_COUNT, 8'd0);
    quiet = 1;
    test_pursuit(230);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

FILE: waypoint_turn_then_drive_controller.f
rtl/wtd_pkg.sv
rtl/wtd_ram.sv
rtl/wtd_cordic.sv
rtl/wtd_sqrt.sv
rtl/wtd_div.sv
rtl/waypoint_turn_then_drive_controller.sv
dv/tb_waypoint_turn_then_drive_controller.sv
